FILE: rtl/mhrk_pkg.sv
`timescale 1ns / 1ps

package mhrk_pkg;

  // Field widths of one beat on each side
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OIDX_W   = 6;
  localparam int unsigned OCNT_W   = 7;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPLACE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] target_value;
    logic signed [VALUE_W-1:0] new_value;
  } mhrk_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [OIDX_W-1:0]         final_index;
    logic signed [VALUE_W-1:0] smallest_value;
    logic [OCNT_W-1:0]         element_count;
  } mhrk_result_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_LOAD,
    S_SCAN,
    S_UP_RD,
    S_UP_CMP,
    S_DN_L,
    S_DN_R,
    S_DN_RC,
    S_DN_CMP,
    S_FINAL,
    S_DONE
  } mhrk_state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLEAR,
    OP_LOAD,
    OP_SCAN,
    OP_UP_RD,
    OP_UP_CMP,
    OP_DN_L,
    OP_DN_R,
    OP_DN_RC,
    OP_DN_CMP,
    OP_FINAL
  } mhrk_op_t;

  typedef struct packed {
    mhrk_op_t op;
  } mhrk_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              hit;        // scanned entry equals target
    logic              miss;       // scan ran past the last entry
    logic              pos_zero;   // hole sits at the root
    logic              moved;      // sift-up moved at least once
    logic              up_less;    // new value below parent
    logic              left_ok;    // left child exists
    logic              right_ok;   // right child exists
    logic              dn_greater; // new value above smaller child
  } mhrk_stat_t;

endpackage

FILE: rtl/mhrk_ram.sv
`timescale 1ns / 1ps

module mhrk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mhrk_dp.sv
`timescale 1ns / 1ps

module mhrk_dp import mhrk_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  mhrk_cmd_t    cmd,
  input  mhrk_item_t   item,
  output mhrk_stat_t   stat,
  output mhrk_result_t result
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = IW + 2;

  // Item registers
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] target;
  logic signed [VALUE_W-1:0] value;

  // Heap bookkeeping
  logic [CW-1:0]             count;
  logic [IW-1:0]             pos;
  logic [IW-1:0]             scan;
  logic [IW-1:0]             cmp_addr;
  logic                      cmp_valid;
  logic                      moved;
  logic signed [VALUE_W-1:0] pick_val;
  logic [IW-1:0]             pick_idx;
  logic signed [VALUE_W-1:0] root;
  logic [STATUS_W-1:0]       status;

  // Memory port
  logic                      ram_we;
  logic [IW-1:0]             ram_waddr;
  logic signed [VALUE_W-1:0] ram_wdata;
  logic [IW-1:0]             ram_raddr;
  logic signed [VALUE_W-1:0] rdata;

  // Index arithmetic
  logic [CW-1:0] last;
  logic [IW-1:0] parent;
  logic [XW-1:0] left_x;
  logic [XW-1:0] right_x;
  logic [XW-1:0] count_x;
  logic          full;

  assign last    = count - CW'(1);
  assign parent  = IW'((pos - IW'(1)) >> 1);
  assign left_x  = XW'({pos, 1'b1});
  assign right_x = left_x + XW'(1);
  assign count_x = XW'(count);
  assign full    = (count == CW'(DEPTH));

  // Status toward the controller
  always_comb begin
    stat.kind       = kind;
    stat.hit        = cmp_valid && (rdata == target);
    stat.miss       = (count == '0) ||
                      (cmp_valid && (rdata != target) && (CW'(cmp_addr) == last));
    stat.pos_zero   = (pos == '0);
    stat.moved      = moved;
    stat.up_less    = (value < rdata);
    stat.left_ok    = (left_x < count_x);
    stat.right_ok   = (right_x < count_x);
    stat.dn_greater = (value > pick_val);
  end

  // Memory write and read address selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = value;
    ram_raddr = scan;
    unique case (cmd.op)
      OP_LOAD: begin
        ram_we    = !full;
        ram_waddr = count[IW-1:0];
      end
      OP_UP_RD:  ram_raddr = parent;
      OP_UP_CMP: begin
        ram_we    = stat.up_less;
        ram_wdata = rdata;
      end
      OP_DN_L:   ram_raddr = left_x[IW-1:0];
      OP_DN_R:   ram_raddr = right_x[IW-1:0];
      OP_DN_CMP: begin
        ram_we    = stat.dn_greater;
        ram_wdata = pick_val;
      end
      OP_FINAL:  ram_we = 1'b1;
      default: begin
      end
    endcase
  end

  mhrk_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cmp_valid <= 1'b0;
      moved     <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_ACCEPT: begin
          cmp_valid <= 1'b0;
          moved     <= 1'b0;
        end
        OP_CLEAR: count <= '0;
        OP_LOAD: begin
          if (!full) begin
            count <= count + CW'(1);
          end
        end
        OP_SCAN: begin
          if (!stat.hit && !stat.miss) begin
            cmp_valid <= 1'b1;
          end
        end
        OP_UP_CMP: begin
          if (stat.up_less) begin
            moved <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        kind   <= item.kind;
        target <= item.target_value;
        value  <= item.new_value;
        status <= STAT_OK;
        pos    <= '0;
        scan   <= '0;
      end
      OP_LOAD: begin
        if (full) begin
          status <= STAT_FULL;
        end else begin
          pos <= count[IW-1:0];
        end
      end
      OP_SCAN: begin
        if (stat.hit) begin
          pos <= cmp_addr;
        end else if (stat.miss) begin
          status <= STAT_MISS;
        end else begin
          cmp_addr <= scan;
          if (CW'(scan) != last) begin
            scan <= scan + IW'(1);
          end
        end
      end
      OP_UP_CMP: begin
        if (stat.up_less) begin
          pos <= parent;
        end
      end
      OP_DN_R: begin
        pick_val <= rdata;
        pick_idx <= left_x[IW-1:0];
      end
      OP_DN_RC: begin
        if (rdata < pick_val) begin
          pick_val <= rdata;
          pick_idx <= right_x[IW-1:0];
        end
      end
      OP_DN_CMP: begin
        if (stat.dn_greater) begin
          pos <= pick_idx;
        end
      end
      default: begin
      end
    endcase
    // Root mirror follows every write to entry zero
    if (ram_we && (ram_waddr == '0)) begin
      root <= ram_wdata;
    end
  end

  // Result fields
  always_comb begin
    result.status         = status;
    result.final_index    = OIDX_W'(pos);
    result.smallest_value = (count != '0) ? root : '0;
    result.element_count  = OCNT_W'(count);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_full_only_at_depth: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD) && (count != CW'(DEPTH)) |=> (status != STAT_FULL))
    else $error("full status with room left");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    (status == STAT_MISS) |-> (pos == '0))
    else $error("nonzero index on missing target");

endmodule

FILE: rtl/mhrk_ctrl.sv
`timescale 1ns / 1ps

module mhrk_ctrl import mhrk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  mhrk_stat_t stat,
  output mhrk_cmd_t  cmd,
  output logic       busy,
  output logic       strobe
);

  mhrk_state_t state;
  mhrk_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.kind)
          KIND_CLEAR:   state_next = S_CLEAR;
          KIND_LOAD:    state_next = S_LOAD;
          KIND_REPLACE: state_next = S_SCAN;
          default:      state_next = S_DONE;
        endcase
      end
      S_CLEAR: state_next = S_DONE;
      S_LOAD:  state_next = S_DONE;
      S_SCAN: begin
        if (stat.hit) begin
          state_next = S_UP_RD;
        end else if (stat.miss) begin
          state_next = S_DONE;
        end
      end
      S_UP_RD: begin
        if (!stat.pos_zero) begin
          state_next = S_UP_CMP;
        end else if (stat.moved) begin
          state_next = S_FINAL;
        end else begin
          state_next = S_DN_L;
        end
      end
      S_UP_CMP: begin
        if (stat.up_less) begin
          state_next = S_UP_RD;
        end else if (stat.moved) begin
          state_next = S_FINAL;
        end else begin
          state_next = S_DN_L;
        end
      end
      S_DN_L:   state_next = stat.left_ok ? S_DN_R : S_FINAL;
      S_DN_R:   state_next = stat.right_ok ? S_DN_RC : S_DN_CMP;
      S_DN_RC:  state_next = S_DN_CMP;
      S_DN_CMP: state_next = stat.dn_greater ? S_DN_L : S_FINAL;
      S_FINAL:  state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.op = OP_NONE;
    busy   = (state != S_IDLE);
    strobe = (state == S_DONE);
    unique case (state)
      S_IDLE:   cmd.op = start ? OP_ACCEPT : OP_NONE;
      S_CLEAR:  cmd.op = OP_CLEAR;
      S_LOAD:   cmd.op = OP_LOAD;
      S_SCAN:   cmd.op = OP_SCAN;
      S_UP_RD:  cmd.op = OP_UP_RD;
      S_UP_CMP: cmd.op = OP_UP_CMP;
      S_DN_L:   cmd.op = OP_DN_L;
      S_DN_R:   cmd.op = OP_DN_R;
      S_DN_RC:  cmd.op = OP_DN_RC;
      S_DN_CMP: cmd.op = OP_DN_CMP;
      S_FINAL:  cmd.op = OP_FINAL;
      default:  cmd.op = OP_NONE;
    endcase
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && start |=> (state == S_DECODE))
    else $error("accepted beat not decoded");

  a_result_then_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !busy)
    else $error("busy after result beat");

endmodule

FILE: rtl/min_heap_replace_key.sv
`timescale 1ns / 1ps

// Binary min-heap of signed 32-bit values with replace-key. A beat is taken
// when start is high and busy is low; exactly one result beat follows, shown
// for a single cycle with strobe high, and it cannot be held off by the
// receiver. Clear and load pass decode and their own state before the result,
// unused kinds go from decode straight to the result, and busy drops after the
// result before the next beat can be taken. A replace decodes, then scans the
// heap memory one entry per cycle until it finds a match or passes the last
// entry. The new value then sifts up, with a parent read and a compare per
// level, or down, with a read of each child, a pick of the smaller and a
// compare per level, and ends with the final write. The heap memory has a
// single read port. Loads must build a valid heap.
module min_heap_replace_key import mhrk_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  mhrk_item_t   item,
  output logic         busy,
  output logic         strobe,
  output mhrk_result_t result
);

  mhrk_cmd_t  cmd;
  mhrk_stat_t stat;

  mhrk_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  mhrk_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .stat   (stat),
    .result (result)
  );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mhrk_pkg::*;

  localparam int HEAP_DEPTH  = 64;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 120;

  // kind value with no operation behind it
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  typedef struct {
    mhrk_item_t   beat;
    bit           typed;
    mhrk_result_t want;
  } dir_row_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  mhrk_item_t   item_bus = '0;
  logic         busy;
  logic         strobe;
  mhrk_result_t result;

  // mirror of the heap contents, updated when a beat is taken
  logic signed [VALUE_W-1:0] heap_mirror [HEAP_DEPTH];
  int                        mirror_len = 0;
  int                        fill_cap = HEAP_DEPTH;

  mhrk_result_t pending_results [$];
  mhrk_result_t want_beat;
  dir_row_t     dir_table [$];
  int unsigned  err_count = 0;
  int unsigned  stall_cycles = 0;

  min_heap_replace_key #(.DEPTH(HEAP_DEPTH)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item_bus),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Apply one beat to the mirror and return the result it should produce
  function automatic mhrk_result_t apply_heap_op(mhrk_item_t b);
    mhrk_result_t              r;
    int                        i;
    int                        pos;
    int                        lft;
    int                        pick;
    bit                        moving;
    logic signed [VALUE_W-1:0] tmp;
    r = '0;
    r.status = STAT_OK;
    case (b.kind)
      KIND_CLEAR: begin
        mirror_len = 0;
      end
      KIND_LOAD: begin
        if (mirror_len >= HEAP_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          heap_mirror[mirror_len] = b.new_value;
          r.final_index = mirror_len[OIDX_W-1:0];
          mirror_len++;
        end
      end
      KIND_REPLACE: begin
        i = 0;
        while (i < mirror_len && heap_mirror[i] != b.target_value) i++;
        if (i >= mirror_len) begin
          r.status = STAT_MISS;
        end else begin
          heap_mirror[i] = b.new_value;
          pos = i;
          // toward the root while strictly below the parent
          while (pos > 0 && heap_mirror[pos] < heap_mirror[(pos - 1) / 2]) begin
            tmp = heap_mirror[pos];
            heap_mirror[pos] = heap_mirror[(pos - 1) / 2];
            heap_mirror[(pos - 1) / 2] = tmp;
            pos = (pos - 1) / 2;
          end
          // otherwise toward the smaller child, left on a tie
          moving = (pos == i);
          while (moving) begin
            lft = 2 * pos + 1;
            if (lft >= mirror_len) begin
              moving = 1'b0;
            end else begin
              pick = lft;
              if (lft + 1 < mirror_len && heap_mirror[lft] > heap_mirror[lft + 1])
                pick = lft + 1;
              if (heap_mirror[pos] > heap_mirror[pick]) begin
                tmp = heap_mirror[pos];
                heap_mirror[pos] = heap_mirror[pick];
                heap_mirror[pick] = tmp;
                pos = pick;
              end else begin
                moving = 1'b0;
              end
            end
          end
          r.final_index = pos[OIDX_W-1:0];
        end
      end
      default: ;
    endcase
    r.smallest_value = (mirror_len > 0) ? heap_mirror[0] : '0;
    r.element_count  = mirror_len[OCNT_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t dir_row(logic [KIND_W-1:0] k, int t, int v, bit typed,
                                       logic [STATUS_W-1:0] st, int idx, int root, int cnt);
    dir_row_t row;
    row.beat.kind                = k;
    row.beat.target_value        = t;
    row.beat.new_value           = v;
    row.typed                    = typed;
    row.want.status              = st;
    row.want.final_index         = idx[OIDX_W-1:0];
    row.want.smallest_value      = root;
    row.want.element_count       = cnt[OCNT_W-1:0];
    return row;
  endfunction

  // Mix of extremes, values around zero and full-range words
  function automatic logic signed [VALUE_W-1:0] rand_word();
    logic signed [VALUE_W-1:0] w;
    case ($urandom_range(0, 7))
      0:       w = WORD_MIN;
      1:       w = WORD_MAX;
      2, 3:    w = $urandom_range(0, 40) - 20;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Next random beat: mostly loads that keep the heap valid and replaces of
  // values that are present, with clears, spare kinds and odd loads mixed in
  function automatic mhrk_item_t next_heap_beat();
    mhrk_item_t b;
    int         r;
    longint     parent_val;
    longint     step;
    longint     sum;
    r = $urandom_range(0, 99);
    b.target_value = $urandom;
    b.new_value    = $urandom;
    if (r < 2 || (mirror_len >= fill_cap && r < 6)) begin
      b.kind = KIND_CLEAR;
      fill_cap = ($urandom_range(0, 5) == 0) ? HEAP_DEPTH : $urandom_range(1, 16);
    end else if (r < 8) begin
      b.kind = KIND_SPARE;
    end else if (r < 10) begin
      b.kind      = KIND_LOAD;
      b.new_value = rand_word();
    end else if ((mirror_len < fill_cap && r < 50) || r < 13) begin
      b.kind = KIND_LOAD;
      if (mirror_len == 0 || mirror_len >= HEAP_DEPTH) begin
        b.new_value = rand_word();
      end else begin
        parent_val = heap_mirror[(mirror_len - 1) / 2];
        case ($urandom_range(0, 3))
          0:       step = 0;
          1, 2:    step = $urandom_range(0, 50);
          default: step = $urandom;
        endcase
        sum = parent_val + step;
        b.new_value = (sum > longint'(WORD_MAX)) ? WORD_MAX : sum[VALUE_W-1:0];
      end
    end else begin
      b.kind = KIND_REPLACE;
      if (mirror_len > 0 && $urandom_range(0, 99) < 85)
        b.target_value = heap_mirror[$urandom_range(0, mirror_len - 1)];
      else
        b.target_value = rand_word();
      case ($urandom_range(0, 3))
        0: b.new_value = rand_word();
        1: b.new_value = b.target_value + $urandom_range(0, 6) - 3;
        2: b.new_value = (mirror_len > 0) ? heap_mirror[$urandom_range(0, mirror_len - 1)]
                                          : rand_word();
        default: ;
      endcase
    end
    return b;
  endfunction

  // Drive one beat; start stays high after the accept edge
  task automatic send_beat(mhrk_item_t b, bit typed, mhrk_result_t want, int idle_pct);
    mhrk_result_t predicted;
    int           gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (idle_pct > 0 && $urandom_range(0, 15) == 0) gap += $urandom_range(1, 110);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    item_bus <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_heap_op(b);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Hold the sender off until every result is back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int n, int idle_pct);
    mhrk_item_t b;
    int         done_cnt;
    done_cnt = 0;
    while (done_cnt < n) begin
      b = next_heap_beat();
      if ($urandom_range(0, 49) == 0) settle();
      send_beat(b, 1'b0, '0, idle_pct);
      done_cnt++;
    end
  endtask

  // Stimulus
  initial begin
    // empty heap, then a small valid heap with equal parent-child pairs and extremes
    dir_table.push_back(dir_row(KIND_REPLACE, 0, 5, 1, STAT_MISS, 0, 0, 0));
    dir_table.push_back(dir_row(KIND_SPARE, -1, -1, 1, STAT_OK, 0, 0, 0));
    dir_table.push_back(dir_row(KIND_LOAD, 0, WORD_MIN, 1, STAT_OK, 0, WORD_MIN, 1));
    dir_table.push_back(dir_row(KIND_LOAD, 0, -5, 1, STAT_OK, 1, WORD_MIN, 2));
    dir_table.push_back(dir_row(KIND_LOAD, 0, 100, 1, STAT_OK, 2, WORD_MIN, 3));
    dir_table.push_back(dir_row(KIND_LOAD, 0, -5, 1, STAT_OK, 3, WORD_MIN, 4));
    dir_table.push_back(dir_row(KIND_LOAD, 0, 7, 1, STAT_OK, 4, WORD_MIN, 5));
    dir_table.push_back(dir_row(KIND_LOAD, 0, 100, 1, STAT_OK, 5, WORD_MIN, 6));
    dir_table.push_back(dir_row(KIND_LOAD, 0, WORD_MAX, 1, STAT_OK, 6, WORD_MIN, 7));
    // sift up from a leaf, sift down from the root, miss on a filled heap
    dir_table.push_back(dir_row(KIND_REPLACE, 7, -100, 0, STAT_OK, 0, 0, 0));
    dir_table.push_back(dir_row(KIND_REPLACE, WORD_MIN, WORD_MAX, 0, STAT_OK, 0, 0, 0));
    dir_table.push_back(dir_row(KIND_REPLACE, 12345, 0, 0, STAT_OK, 0, 0, 0));
    dir_table.push_back(dir_row(KIND_REPLACE, -5, -5, 0, STAT_OK, 0, 0, 0));
    dir_table.push_back(dir_row(KIND_REPLACE, WORD_MAX, WORD_MIN, 0, STAT_OK, 0, 0, 0));
    dir_table.push_back(dir_row(KIND_SPARE, WORD_MIN, WORD_MAX, 0, STAT_OK, 0, 0, 0));
    dir_table.push_back(dir_row(KIND_CLEAR, -1, -1, 1, STAT_OK, 0, 0, 0));
    // equal children: left one wins; equal parent stops the climb
    dir_table.push_back(dir_row(KIND_LOAD, 0, 1, 1, STAT_OK, 0, 1, 1));
    dir_table.push_back(dir_row(KIND_LOAD, 0, 5, 1, STAT_OK, 1, 1, 2));
    dir_table.push_back(dir_row(KIND_LOAD, 0, 5, 1, STAT_OK, 2, 1, 3));
    dir_table.push_back(dir_row(KIND_REPLACE, 1, 9, 1, STAT_OK, 1, 5, 3));
    dir_table.push_back(dir_row(KIND_REPLACE, 9, 5, 0, STAT_OK, 0, 0, 0));
    dir_table.push_back(dir_row(KIND_REPLACE, 5, WORD_MIN, 0, STAT_OK, 0, 0, 0));
    dir_table.push_back(dir_row(KIND_CLEAR, 0, 0, 1, STAT_OK, 0, 0, 0));
    // fill to the top with a rising heap, one load past full, then a climb
    // from the last entry and a fall from the root
    for (int k = 0; k < HEAP_DEPTH; k++)
      dir_table.push_back(dir_row(KIND_LOAD, 0, 3 * k - 90, 1, STAT_OK, k, -90, k + 1));
    dir_table.push_back(dir_row(KIND_LOAD, 0, 500, 1, STAT_FULL, 0, -90, HEAP_DEPTH));
    dir_table.push_back(dir_row(KIND_REPLACE, 3 * (HEAP_DEPTH - 1) - 90, WORD_MIN, 0,
                                STAT_OK, 0, 0, 0));
    dir_table.push_back(dir_row(KIND_REPLACE, WORD_MIN, WORD_MAX, 0, STAT_OK, 0, 0, 0));
    dir_table.push_back(dir_row(KIND_CLEAR, 0, 0, 1, STAT_OK, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[n]) send_beat(dir_table[n].beat, dir_table[n].typed,
                                     dir_table[n].want, 8);
    settle();

    // random stretches: sender idles rarely, then often, then never
    run_random(390, 8);
    settle();
    run_random(390, 71);
    settle();
    run_random(380, 0);
    settle();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected, got %h", $time, result);
        err_count++;
      end else begin
        want_beat = pending_results.pop_front();
        if (result.status !== want_beat.status) begin
          $display("%0t: status exp %0d got %0d", $time, want_beat.status, result.status);
          err_count++;
        end
        if (result.final_index !== want_beat.final_index) begin
          $display("%0t: final_index exp %0d got %0d", $time,
                   want_beat.final_index, result.final_index);
          err_count++;
        end
        if (result.smallest_value !== want_beat.smallest_value) begin
          $display("%0t: smallest_value exp %0d got %0d", $time,
                   want_beat.smallest_value, result.smallest_value);
          err_count++;
        end
        if (result.element_count !== want_beat.element_count) begin
          $display("%0t: element_count exp %0d got %0d", $time,
                   want_beat.element_count, result.element_count);
          err_count++;
        end
      end
    end
  end

  // Watchdog: no beat taken on either side for too long
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule
